>>> hdl/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, constants and the glyph table of the bitmap font rasterizer.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int DEF_SCREEN_COLUMNS = 320;
  localparam int DEF_SCREEN_ROWS    = 200;
  localparam int JOB_QUEUE_DEPTH    = 2;

  localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0]  GLYPH_FIRST  = 8'h20;
  localparam logic [7:0]  GLYPH_LAST   = 8'h5A;
  localparam logic [7:0]  LOWER_FIRST  = 8'h61;
  localparam logic [7:0]  LOWER_LAST   = 8'h7A;
  localparam logic [7:0]  CASE_OFFSET  = 8'h20;
  localparam logic [15:0] LINE_STEP    = 16'd10;
  localparam logic [15:0] ADVANCE      = 16'd8;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        string_start;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  ink_color;
  } bfr_in_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] pixel_address;
    logic [7:0]  pixel_color;
    logic        last_pixel;
  } bfr_out_t;

  // One character to draw: visible set bits (row r in bits 8r+7..8r, bit 7 is
  // the leftmost column), the low bits of the cursor and the ink.
  typedef struct packed {
    logic [63:0] mask;
    logic [11:0] base_x;
    logic [11:0] base_y;
    logic [7:0]  color;
  } bfr_job_t;

  // Glyph rows for codes 0x20 to 0x5A, top row in bits 63..56.
  function automatic logic [63:0] bfr_glyph_bits(input logic [5:0] idx);
    logic [63:0] bits;
    case (idx)
      6'd0:  bits = 64'h0000000000000000;
      6'd1:  bits = 64'h183C3C1818001800;
      6'd2:  bits = 64'h3636000000000000;
      6'd3:  bits = 64'h367F36367F363600;
      6'd4:  bits = 64'h0C3E031E301F0C00;
      6'd5:  bits = 64'h006333180C666300;
      6'd6:  bits = 64'h1C361C6E3B336E00;
      6'd7:  bits = 64'h0606030000000000;
      6'd8:  bits = 64'h180C0606060C1800;
      6'd9:  bits = 64'h060C1818180C0600;
      6'd10: bits = 64'h00663CFF3C660000;
      6'd11: bits = 64'h000C0C7F0C0C0000;
      6'd12: bits = 64'h00000000000C0600;
      6'd13: bits = 64'h0000007F00000000;
      6'd14: bits = 64'h00000000000C0C00;
      6'd15: bits = 64'h6030180C06030100;
      6'd16: bits = 64'h3E63737B6F673E00;
      6'd17: bits = 64'h0C0E0C0C0C0C3F00;
      6'd18: bits = 64'h1E33301C06333F00;
      6'd19: bits = 64'h1E33301C30331E00;
      6'd20: bits = 64'h383C36337F307800;
      6'd21: bits = 64'h3F031F3030331E00;
      6'd22: bits = 64'h1C06031F33331E00;
      6'd23: bits = 64'h3F3330180C0C0C00;
      6'd24: bits = 64'h1E33331E33331E00;
      6'd25: bits = 64'h1E33333E30180E00;
      6'd26: bits = 64'h000C0C00000C0C00;
      6'd27: bits = 64'h000C0C00000C0600;
      6'd28: bits = 64'h180C0603060C1800;
      6'd29: bits = 64'h00007F00007F0000;
      6'd30: bits = 64'h060C1830180C0600;
      6'd31: bits = 64'h1E3330180C000C00;
      6'd32: bits = 64'h3E637B7B7B031E00;
      6'd33: bits = 64'h0C1E33333F333300;
      6'd34: bits = 64'h3F66663E66663F00;
      6'd35: bits = 64'h3C66030303663C00;
      6'd36: bits = 64'h1F36666666361F00;
      6'd37: bits = 64'h7F06063E06067F00;
      6'd38: bits = 64'h7F06063E06060600;
      6'd39: bits = 64'h3C66030373667C00;
      6'd40: bits = 64'h3333333F33333300;
      6'd41: bits = 64'h1E0C0C0C0C0C1E00;
      6'd42: bits = 64'h7830303033331E00;
      6'd43: bits = 64'h6766361E36666700;
      6'd44: bits = 64'h0606060606067F00;
      6'd45: bits = 64'h63777F6B63636300;
      6'd46: bits = 64'h63676F7B73636300;
      6'd47: bits = 64'h1C36636363361C00;
      6'd48: bits = 64'h3F66663E06060600;
      6'd49: bits = 64'h1E3333333B1E3800;
      6'd50: bits = 64'h3F66663E36666700;
      6'd51: bits = 64'h1E33070E38331E00;
      6'd52: bits = 64'h3F2D0C0C0C0C1E00;
      6'd53: bits = 64'h3333333333331E00;
      6'd54: bits = 64'h33333333331E0C00;
      6'd55: bits = 64'h6363636B7F776300;
      6'd56: bits = 64'h6363361C1C366300;
      6'd57: bits = 64'h3333331E0C0C1E00;
      6'd58: bits = 64'h7F6331184C667F00;
      default: bits = 64'h0000000000000000;
    endcase
    return bits;
  endfunction

endpackage

>>> hdl/bfr_front.sv
// ----------------------------------------------------------------------------
// bfr_front
// Takes text bytes, keeps the cursor and origin, and queues visible glyphs.
// ----------------------------------------------------------------------------
module bfr_front import bfr_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bfr_in_t  in_data,
  output logic     job_valid,
  input  logic     job_ready,
  output bfr_job_t job_data
);

  localparam logic [15:0] COLS_16  = 16'(SCREEN_COLUMNS);
  localparam logic [15:0] ROWS_16  = 16'(SCREEN_ROWS);
  localparam logic [15:0] WRAP_COL = 16'(SCREEN_COLUMNS - 8);

  logic [15:0] home_x_r, home_x_nxt, home_y_r, home_y_nxt;
  logic [15:0] cursor_x_r, cursor_x_nxt, cursor_y_r, cursor_y_nxt;

  logic [15:0] hx, hy, cx, cy, adv_x;
  logic [7:0]  code;
  logic        is_nl, is_glyph, accept;
  logic [63:0] rom_bits, mask;
  logic [7:0]  row_ok, col_ok;

  assign in_ready = job_ready;
  assign accept   = in_valid & in_ready;

  always_comb begin
    hx = in_data.string_start ? in_data.origin_x : home_x_r;
    hy = in_data.string_start ? in_data.origin_y : home_y_r;
    cx = in_data.string_start ? in_data.origin_x : cursor_x_r;
    cy = in_data.string_start ? in_data.origin_y : cursor_y_r;

    code = in_data.char_code;
    if (code >= LOWER_FIRST && code <= LOWER_LAST) begin
      code = code - CASE_OFFSET;
    end
    is_nl    = (in_data.char_code == CHAR_NEWLINE);
    is_glyph = !is_nl && (code >= GLYPH_FIRST) && (code <= GLYPH_LAST);
    rom_bits = bfr_glyph_bits(6'(code - GLYPH_FIRST));

    for (int i = 0; i < 8; i++) begin
      row_ok[i] = (16'(cy + 16'(i)) < ROWS_16);
      col_ok[i] = (16'(cx + 16'(i)) < COLS_16);
    end
    // Bit b of a row byte is column 7-b.
    for (int r = 0; r < 8; r++) begin
      for (int b = 0; b < 8; b++) begin
        mask[8*r + b] = rom_bits[56 - 8*r + b] & row_ok[r] & col_ok[7 - b];
      end
    end

    adv_x = cx + ADVANCE;

    home_x_nxt   = home_x_r;
    home_y_nxt   = home_y_r;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    if (accept) begin
      home_x_nxt = hx;
      home_y_nxt = hy;
      if (is_nl) begin
        cursor_x_nxt = hx;
        cursor_y_nxt = cy + LINE_STEP;
      end else if (!is_glyph || adv_x < WRAP_COL) begin
        cursor_x_nxt = adv_x;
        cursor_y_nxt = cy;
      end else begin
        cursor_x_nxt = hx;
        cursor_y_nxt = cy + LINE_STEP;
      end
    end
  end

  assign job_valid       = accept & is_glyph & (mask != 64'd0);
  assign job_data.mask   = mask;
  assign job_data.base_x = cx[11:0];
  assign job_data.base_y = cy[11:0];
  assign job_data.color  = in_data.ink_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_x_r   <= '0;
      home_y_r   <= '0;
      cursor_x_r <= '0;
      cursor_y_r <= '0;
    end else begin
      home_x_r   <= home_x_nxt;
      home_y_r   <= home_y_nxt;
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
    end
  end

endmodule

>>> hdl/bfr_queue.sv
// ----------------------------------------------------------------------------
// bfr_queue
// Short register queue of glyph jobs between the front and the back.
// ----------------------------------------------------------------------------
module bfr_queue import bfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  bfr_job_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output bfr_job_t pop_data
);

  localparam int DEPTH = JOB_QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bfr_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/bfr_back.sv
// ----------------------------------------------------------------------------
// bfr_back
// Walks a glyph job's visible bits: one pixel write a cycle while not stalled.
// ----------------------------------------------------------------------------
module bfr_back import bfr_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  output logic     job_ready,
  input  bfr_job_t job_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bfr_out_t out_data
);

  localparam logic [12:0] COLS_13 = 13'(SCREEN_COLUMNS);

  // Scan stage.
  logic        busy_r, busy_nxt;
  bfr_job_t    job_r, job_nxt;
  logic [2:0]  row_r, row_nxt;
  logic [7:0]  row_bits;
  logic [2:0]  sel_b;
  logic [63:0] mask_clr;
  logic        emit;

  // Coordinate stage.
  logic        mid_valid_r, mid_valid_nxt;
  logic [11:0] mid_px_r, mid_py_r;
  logic [7:0]  mid_color_r;
  logic        mid_last_r;
  logic        mid_ready;

  // Output stage.
  logic        out_valid_r, out_valid_nxt;
  bfr_out_t    out_r;
  logic        out_free;
  logic [24:0] addr_full;

  assign out_free  = !out_valid_r || out_ready;
  assign mid_ready = !mid_valid_r || out_free;

  always_comb begin
    row_bits = job_r.mask[{row_r, 3'b000} +: 8];
    sel_b    = '0;
    for (int i = 0; i < 8; i++) begin
      if (row_bits[i]) begin
        sel_b = 3'(i);
      end
    end
    mask_clr = job_r.mask & ~(64'd1 << {row_r, sel_b});
    emit     = busy_r && (row_bits != 8'd0) && mid_ready;

    busy_nxt  = busy_r;
    job_nxt   = job_r;
    row_nxt   = row_r;
    job_ready = 1'b0;
    if (!busy_r) begin
      job_ready = 1'b1;
      if (job_valid) begin
        busy_nxt = 1'b1;
        job_nxt  = job_data;
        row_nxt  = '0;
      end
    end else if (row_bits == 8'd0) begin
      row_nxt = row_r + 1'b1;
    end else if (mid_ready) begin
      job_nxt.mask = mask_clr;
      if (mask_clr == 64'd0) begin
        busy_nxt = 1'b0;
      end
    end

    mid_valid_nxt = mid_ready ? emit : mid_valid_r;
    out_valid_nxt = out_free ? mid_valid_r : out_valid_r;
    addr_full     = ({13'd0, mid_py_r} * {12'd0, COLS_13}) + {13'd0, mid_px_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      mid_valid_r <= mid_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    row_r <= row_nxt;
    if (emit) begin
      mid_px_r    <= job_r.base_x + {9'd0, ~sel_b};
      mid_py_r    <= job_r.base_y + {9'd0, row_r};
      mid_color_r <= job_r.color;
      mid_last_r  <= (mask_clr == 64'd0);
    end
    if (mid_valid_r && out_free) begin
      out_r.pixel_x       <= mid_px_r;
      out_r.pixel_y       <= mid_py_r;
      out_r.pixel_address <= addr_full[23:0];
      out_r.pixel_color   <= mid_color_r;
      out_r.last_pixel    <= mid_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hdl/bitmap_font_text_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_rasterizer_unit
// Turns a stream of text bytes into 8-bit framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Each input transfer carries one text byte. The front end takes one byte per
// cycle while the glyph job queue has room: it folds lower case to upper case,
// handles newline and unknown bytes by moving the cursor alone, and for a
// printable character looks up the 8x8 glyph, masks off the bits that fall
// outside the screen, and queues the remaining bits as one job. The back end
// issues one pixel write per cycle from the oldest job while the output is
// not stalled, so the time a character takes grows with its visible pixels,
// with the glyph rows with nothing left to draw that the scan passes over,
// and with the loading of the job. That back-end scan is what sets the
// sustained rate. Newlines, unknown bytes and characters with no visible
// pixel are consumed by the front end alone and never reach the back end.
// Once the back end has loaded a job and skipped any empty leading rows,
// each pixel write is registered in the coordinate stage and then in the
// output stage. Each write is held until it is transferred; last_pixel
// marks the final write of each character that has any.
// ----------------------------------------------------------------------------
module bitmap_font_text_rasterizer_unit import bfr_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bfr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bfr_out_t out_data
);

  // Front end to queue.
  logic     fq_valid, fq_ready;
  bfr_job_t fq_data;

  // Queue to back end.
  logic     qb_valid, qb_ready;
  bfr_job_t qb_data;

  // The front end owns the cursor; it only stalls when the queue is full.
  bfr_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  // The queue lets text keep flowing while the back end drains a glyph.
  bfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // The back end scans visible glyph bits and registers each pixel write,
  // including its framebuffer address.
  bfr_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> hdl/bfr_checker.sv
// ----------------------------------------------------------------------------
// bfr_port_checks
// Port-level checks of the pixel write stream, bound to the top level.
// ----------------------------------------------------------------------------
module bfr_port_checks import bfr_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input bfr_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input bfr_out_t out_data
);

  localparam logic [12:0] COLS_13 = 13'(SCREEN_COLUMNS);
  localparam logic [12:0] ROWS_13 = 13'(SCREEN_ROWS);

  logic [24:0] exp_addr;
  logic        in_seen;

  assign exp_addr = ({13'd0, out_data.pixel_y} * {12'd0, COLS_13})
                  + {13'd0, out_data.pixel_x};
  assign in_seen  = in_valid & in_ready & (in_data.char_code == in_data.char_code);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled pixel write changed or dropped");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_data.pixel_x} < COLS_13)
    else $error("pixel column off screen");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_data.pixel_y} < ROWS_13)
    else $error("pixel row off screen");

  a_address: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid || in_seen |-> !out_valid || out_data.pixel_address == exp_addr[23:0])
    else $error("pixel address does not match row and column");

endmodule

bind bitmap_font_text_rasterizer_unit bfr_port_checks #(
  .SCREEN_COLUMNS (SCREEN_COLUMNS),
  .SCREEN_ROWS    (SCREEN_ROWS)
) u_bfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/bfr_checker.sv
// ----------------------------------------------------------------------------
// bfr_checker
// Predicts and checks the pixel writes of the bitmap font rasterizer.
// ----------------------------------------------------------------------------
// Watches both channels. Each text byte taken by the block updates a private
// copy of the origin and the cursor. Each byte also appends the pixel writes
// that it should cause to a queue. Each pixel write given by the block is
// compared field by field with the oldest queued write.
// ----------------------------------------------------------------------------
module bfr_checker import bfr_pkg::*; #(
  parameter int COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int ROWS    = DEF_SCREEN_ROWS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  bfr_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  bfr_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] font_rows [59];
  logic [15:0] home_x, home_y, cur_x, cur_y;
  bfr_out_t    pixel_writes_q [$];
  int          mismatches;
  int          writes_seen;

  // Glyph rows for codes 0x20 to 0x5A. The top row sits in the high byte.
  initial begin
    font_rows = '{
      64'h0000000000000000, 64'h183C3C1818001800, 64'h3636000000000000,
      64'h367F36367F363600, 64'h0C3E031E301F0C00, 64'h006333180C666300,
      64'h1C361C6E3B336E00, 64'h0606030000000000, 64'h180C0606060C1800,
      64'h060C1818180C0600, 64'h00663CFF3C660000, 64'h000C0C7F0C0C0000,
      64'h00000000000C0600, 64'h0000007F00000000, 64'h00000000000C0C00,
      64'h6030180C06030100, 64'h3E63737B6F673E00, 64'h0C0E0C0C0C0C3F00,
      64'h1E33301C06333F00, 64'h1E33301C30331E00, 64'h383C36337F307800,
      64'h3F031F3030331E00, 64'h1C06031F33331E00, 64'h3F3330180C0C0C00,
      64'h1E33331E33331E00, 64'h1E33333E30180E00, 64'h000C0C00000C0C00,
      64'h000C0C00000C0600, 64'h180C0603060C1800, 64'h00007F00007F0000,
      64'h060C1830180C0600, 64'h1E3330180C000C00, 64'h3E637B7B7B031E00,
      64'h0C1E33333F333300, 64'h3F66663E66663F00, 64'h3C66030303663C00,
      64'h1F36666666361F00, 64'h7F06063E06067F00, 64'h7F06063E06060600,
      64'h3C66030373667C00, 64'h3333333F33333300, 64'h1E0C0C0C0C0C1E00,
      64'h7830303033331E00, 64'h6766361E36666700, 64'h0606060606067F00,
      64'h63777F6B63636300, 64'h63676F7B73636300, 64'h1C36636363361C00,
      64'h3F66663E06060600, 64'h1E3333333B1E3800, 64'h3F66663E36666700,
      64'h1E33070E38331E00, 64'h3F2D0C0C0C0C1E00, 64'h3333333333331E00,
      64'h33333333331E0C00, 64'h6363636B7F776300, 64'h6363361C1C366300,
      64'h3333331E0C0C1E00, 64'h7F6331184C667F00
    };
  end

  task automatic report_mismatch(input string what);
    $display("bfr_checker: write %0d: %s", writes_seen, what);
    mismatches++;
  endtask

  task automatic predict_pixel_writes(input bfr_in_t item);
    logic [7:0]  code;
    logic [63:0] bits;
    logic [15:0] px, py;
    bfr_out_t    w;
    int          count;
    code  = item.char_code;
    count = 0;
    if (item.string_start) begin
      home_x = item.origin_x;
      home_y = item.origin_y;
      cur_x  = item.origin_x;
      cur_y  = item.origin_y;
    end
    if (code == CHAR_NEWLINE) begin
      cur_x = home_x;
      cur_y = cur_y + LINE_STEP;
    end else begin
      if (code >= LOWER_FIRST && code <= LOWER_LAST)
        code = code - CASE_OFFSET;
      if (code < GLYPH_FIRST || code > GLYPH_LAST) begin
        // Unknown bytes only move the cursor; no wrap check.
        cur_x = cur_x + ADVANCE;
      end else begin
        bits = font_rows[int'(code - GLYPH_FIRST)];
        for (int row = 0; row < 8; row++) begin
          py = cur_y + 16'(row);
          for (int col = 0; col < 8; col++) begin
            px = cur_x + 16'(col);
            if (bits[63 - 8 * row - col] && int'(py) < ROWS && int'(px) < COLUMNS) begin
              w.pixel_x       = px[11:0];
              w.pixel_y       = py[11:0];
              w.pixel_address = 24'(int'(py) * COLUMNS + int'(px));
              w.pixel_color   = item.ink_color;
              w.last_pixel    = 1'b0;
              pixel_writes_q.push_back(w);
              count++;
            end
          end
        end
        if (count > 0)
          pixel_writes_q[$].last_pixel = 1'b1;
        cur_x = cur_x + ADVANCE;
        if (int'(cur_x) >= COLUMNS - 8) begin
          cur_x = home_x;
          cur_y = cur_y + LINE_STEP;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    bfr_out_t want;
    if (!rst_n) begin
      home_x = '0;
      home_y = '0;
      cur_x  = '0;
      cur_y  = '0;
      pixel_writes_q.delete();
      mismatches  = 0;
      writes_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_writes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected write x=%0d y=%0d",
                                    out_data.pixel_x, out_data.pixel_y));
        end else begin
          want = pixel_writes_q.pop_front();
          if (out_data.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, want %0d", out_data.pixel_x,
                                      want.pixel_x));
          if (out_data.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y %0d, want %0d", out_data.pixel_y,
                                      want.pixel_y));
          if (out_data.pixel_address !== want.pixel_address)
            report_mismatch($sformatf("pixel_address %0d, want %0d",
                                      out_data.pixel_address, want.pixel_address));
          if (out_data.pixel_color !== want.pixel_color)
            report_mismatch($sformatf("pixel_color %0h, want %0h",
                                      out_data.pixel_color, want.pixel_color));
          if (out_data.last_pixel !== want.last_pixel)
            report_mismatch($sformatf("last_pixel %0b, want %0b",
                                      out_data.last_pixel, want.last_pixel));
        end
        writes_seen++;
      end
      if (in_valid && in_ready)
        predict_pixel_writes(in_data);
    end
    fail_count <= mismatches;
    pending    <= pixel_writes_q.size();
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top level of the bitmap font rasterizer testbench.
// ----------------------------------------------------------------------------
// Sends text bytes to the block: first a directed set that hits the field
// extremes, case folding, newline, unknown bytes, blank glyphs, clipping,
// cursor wrap modulo 65536 and the right-edge wrap; then random strings.
// A checker beside the block predicts and compares every pixel write, and
// this module only drives the channels and prints the verdict.
// ----------------------------------------------------------------------------
module tb;
  import bfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = DEF_SCREEN_COLUMNS;
  localparam int ROWS    = DEF_SCREEN_ROWS;

  // Worst case per character: 64 writes, each behind a long stall, plus a
  // long sender gap and the back-end scan. For roughly 450 characters that
  // comes to some 5 ms; the limit allows several times that.
  localparam realtime RUN_LIMIT = 25ms;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  bfr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bfr_out_t out_data;

  int fail_count;
  int pending;

  // While calm is set, neither side idles, so the block runs at full rate.
  bit calm       = 1'b0;
  int stall_left = 0;
  int chars_sent = 0;

  always #2 clk = ~clk;

  bitmap_font_text_rasterizer_unit #(
    .SCREEN_COLUMNS(COLUMNS),
    .SCREEN_ROWS   (ROWS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  bfr_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Length of an idle stretch: zero most of the time, otherwise usually a
  // short one and now and then a long one. gap_pct is the chance of a gap.
  function automatic int idle_length(input int gap_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r >= gap_pct)
      return 0;
    if ($urandom_range(0, 9) != 0)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // The result side stalls on its own schedule. Each stall is drawn when
  // the previous one has run out, so stalls land on every phase of a glyph.
  always @(posedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left = idle_length(15);
      out_ready <= (stall_left == 0);
    end
  end

  function automatic bfr_in_t make_char(input logic [7:0] code, input logic start,
                                        input logic [15:0] ox, input logic [15:0] oy,
                                        input logic [7:0] ink);
    bfr_in_t item;
    item.char_code    = code;
    item.string_start = start;
    item.origin_x     = ox;
    item.origin_y     = oy;
    item.ink_color    = ink;
    return item;
  endfunction

  // Mostly printable characters, some lower case, some newlines and some
  // bytes from the full range, which covers the control and high codes.
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
    if (r < 75)
      return 8'($urandom_range(LOWER_FIRST, LOWER_LAST));
    if (r < 83)
      return CHAR_NEWLINE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one byte and holds it until the transfer happens. Valid is only
  // lowered when a gap follows, so back-to-back bytes keep it high.
  task automatic send_char(input bfr_in_t item);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    gap = calm ? 0 : idle_length(35);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] ox, oy;
    logic [7:0]  ink;
    logic        start;
    bit          broken;
    int          len;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A byte before any string start draws at the reset origin.
    send_char(make_char(8'h41, 1'b0, 16'hFFFF, 16'hFFFF, 8'h11));
    // Plain string at the top-left corner, with lower case folded.
    send_char(make_char(8'h48, 1'b1, 16'h0000, 16'h0000, 8'hFF));
    send_char(make_char(8'h69, 1'b0, 16'h1234, 16'h4321, 8'h00));
    send_char(make_char(8'h61, 1'b0, 16'h0000, 16'h0000, 8'hA5));
    send_char(make_char(8'h7A, 1'b0, 16'h0000, 16'h0000, 8'h5A));
    // Newline, then the blank glyph and both ends of the glyph range.
    send_char(make_char(CHAR_NEWLINE, 1'b0, 16'h0000, 16'h0000, 8'h01));
    send_char(make_char(GLYPH_FIRST, 1'b0, 16'h0000, 16'h0000, 8'h02));
    send_char(make_char(8'h21, 1'b0, 16'h0000, 16'h0000, 8'h03));
    send_char(make_char(GLYPH_LAST, 1'b0, 16'h0000, 16'h0000, 8'h04));
    // Unknown bytes only move the cursor.
    send_char(make_char(8'h00, 1'b0, 16'h0000, 16'h0000, 8'h05));
    send_char(make_char(8'h5B, 1'b0, 16'h0000, 16'h0000, 8'h06));
    send_char(make_char(8'h60, 1'b0, 16'h0000, 16'h0000, 8'h07));
    send_char(make_char(8'h7B, 1'b0, 16'h0000, 16'h0000, 8'h08));
    send_char(make_char(8'h7F, 1'b0, 16'h0000, 16'h0000, 8'h09));
    send_char(make_char(8'h80, 1'b0, 16'h0000, 16'h0000, 8'h0A));
    send_char(make_char(8'hFF, 1'b0, 16'h0000, 16'h0000, 8'h0B));
    // Glyph clipped at the bottom-right corner of the screen.
    send_char(make_char(8'h4D, 1'b1, 16'd316, 16'd196, 8'h77));
    // Cursor near 65535: columns and rows wrap back onto the screen.
    send_char(make_char(8'h23, 1'b1, 16'hFFFC, 16'hFFFC, 8'hC3));
    send_char(make_char(8'h57, 1'b1, 16'hFFFF, 16'hFFFF, 8'h55));
    // Right-edge wrap back to the origin column on the next line.
    send_char(make_char(8'h42, 1'b1, 16'd300, 16'd100, 8'h3C));
    send_char(make_char(8'h43, 1'b0, 16'd0, 16'd0, 8'h3C));
    send_char(make_char(8'h44, 1'b0, 16'd0, 16'd0, 8'h3C));
    // Wholly off screen: a glyph with nothing visible.
    send_char(make_char(8'h58, 1'b1, 16'h8000, 16'h8000, 8'hE7));

    // Random strings. Most start with a string start at an origin on or
    // near the screen; some use any origin, and some lack the start flag
    // or carry a stray one in the middle.
    while (chars_sent < 435) begin
      calm  <= ($urandom_range(0, 4) == 0);
      ink    = 8'($urandom);
      broken = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 4) == 0) begin
        ox = 16'($urandom);
        oy = 16'($urandom);
      end else begin
        ox = 16'($urandom_range(0, COLUMNS + 10));
        oy = 16'($urandom_range(0, ROWS + 10));
      end
      len = $urandom_range(1, 16);
      for (int k = 0; k < len; k++) begin
        start = (k == 0 && !broken) || ($urandom_range(0, 30) == 0);
        if ($urandom_range(0, 7) == 0)
          ink = 8'($urandom);
        send_char(make_char(pick_text_byte(), start,
                            start ? ox : 16'($urandom),
                            start ? oy : 16'($urandom), ink));
      end
    end

    in_valid <= 1'b0;
    calm     <= 1'b0;
    // The pending count is registered, so let it take in the last byte first.
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    // Let a stray write, if the block had one left, show up and be caught.
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

endmodule
